### sv/hpa_pkg.sv
// shared types and constants of the handle pool allocator
`default_nettype none
package hpa_pkg;

  localparam int unsigned SLOTS    = 256;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned COUNT_W  = 9;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_TRY     = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_OWNED = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef logic [HANDLE_W-1:0] handle_t;

  typedef struct packed {
    logic    rd_en;
    logic    pop;
    logic    push;
    handle_t push_data;
  } fifo_req_t;

  typedef struct packed {
    logic               empty;
    logic [COUNT_W-1:0] count;
    handle_t            rd_data;
  } fifo_stat_t;

  typedef struct packed {
    logic    rd_en;
    handle_t rd_addr;
    logic    wr_en;
    handle_t wr_addr;
    logic    wr_data;
  } map_req_t;

endpackage
`default_nettype wire

### sv/hpa_free_fifo.sv
// free list fifo: handle memory with head, tail and fill count
`default_nettype none
module hpa_free_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hpa_pkg::fifo_req_t req,
  output hpa_pkg::fifo_stat_t     stat
);
  import hpa_pkg::*;

  handle_t            queue_mem_r [SLOTS];
  handle_t            rd_data_r;
  handle_t            head_r, head_nxt;
  handle_t            tail_r, tail_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               full;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == COUNT_W'(SLOTS));
  assign do_push = req.push && !full;
  assign do_pop  = req.pop && (count_r != '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_pop) begin
      head_nxt  = head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (do_push) begin
      tail_nxt  = tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue_mem_r[tail_r] <= req.push_data;
    end
    if (req.rd_en) begin
      rd_data_r <= queue_mem_r[head_r];
    end
  end

  assign stat = '{empty: (count_r == '0), count: count_r, rd_data: rd_data_r};

endmodule
`default_nettype wire

### sv/hpa_owned_map.sv
// ownership bitmap memory with per-entry valid bits cleared at reset
`default_nettype none
module hpa_owned_map (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hpa_pkg::map_req_t req,
  output logic                   rd_owned
);
  import hpa_pkg::*;

  logic             map_mem_r [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic             rd_owned_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      map_mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      // entry never written reads as not owned
      rd_owned_r <= valid_r[req.rd_addr] && map_mem_r[req.rd_addr];
    end
  end

  assign rd_owned = rd_owned_r;

endmodule
`default_nettype wire

### sv/handle_pool_allocator.sv
// handle pool allocator top level: request sequencer around the free list and bitmap
// each request passes through an accept cycle that reads both memories and an
// execute state that writes them back and loads the result register
// a new request is not accepted until the previous one has executed
// a waiting result is held while the next request is accepted
// synchronous active-low reset clears pointers, counters and the ownership valid bits
`default_nettype none
module handle_pool_allocator #(
  parameter int unsigned POOL_SIZE = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_handle,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_granted_handle,
  output logic [1:0]      out_status
);
  import hpa_pkg::*;

  localparam int unsigned POOL_LIMIT = (POOL_SIZE > SLOTS) ? SLOTS : POOL_SIZE;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         op_r;
  handle_t            handle_r;
  logic [COUNT_W-1:0] fresh_r, fresh_nxt;
  logic               out_valid_r;
  handle_t            granted_r, granted_nxt;
  logic [1:0]         status_r, status_nxt;

  logic       accept;
  logic       exec_go;
  fifo_req_t  fifo_req;
  fifo_stat_t fifo_stat;
  map_req_t   map_req;
  logic       rd_owned;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // execute only when the result register can take the answer
  assign exec_go  = (state_r == S_EXEC) && !(out_valid_r && out_stall);

  hpa_free_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fifo_req),
    .stat  (fifo_stat)
  );

  hpa_owned_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (map_req),
    .rd_owned (rd_owned)
  );

  always_comb begin
    fifo_req.rd_en     = accept;
    fifo_req.pop       = 1'b0;
    fifo_req.push      = 1'b0;
    fifo_req.push_data = handle_r;
    map_req.rd_en      = accept;
    map_req.rd_addr    = in_handle;
    map_req.wr_en      = 1'b0;
    map_req.wr_addr    = handle_r;
    map_req.wr_data    = 1'b0;
    fresh_nxt          = fresh_r;
    granted_nxt        = '0;
    status_nxt         = ST_OK;
    unique case (op_r)
      OP_ALLOC, OP_TRY: begin
        if (!fifo_stat.empty) begin
          fifo_req.pop    = exec_go;
          map_req.wr_en   = exec_go;
          map_req.wr_addr = fifo_stat.rd_data;
          map_req.wr_data = 1'b1;
          granted_nxt     = fifo_stat.rd_data;
        end else if (op_r == OP_TRY) begin
          status_nxt = ST_EMPTY;
        end else if (fresh_r < COUNT_W'(POOL_LIMIT)) begin
          map_req.wr_en   = exec_go;
          map_req.wr_addr = fresh_r[HANDLE_W-1:0];
          map_req.wr_data = 1'b1;
          granted_nxt     = fresh_r[HANDLE_W-1:0];
          fresh_nxt       = fresh_r + 1'b1;
        end else begin
          status_nxt = ST_EXHAUSTED;
        end
      end
      OP_RELEASE: begin
        if (!rd_owned) begin
          status_nxt = ST_NOT_OWNED;
        end else begin
          map_req.wr_en = exec_go;
          fifo_req.push = exec_go;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        fresh_r     <= fresh_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      handle_r <= in_handle;
    end
    if (exec_go) begin
      granted_r <= granted_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted_handle = granted_r;
  assign out_status         = status_r;

`ifndef SYNTHESIS
  // a request is always followed by its execute cycle
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request accepted without entering execute");

  // the free list never holds more handles than slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.count <= COUNT_W'(SLOTS))
    else $error("free list count overflow");

  // failed requests never hand out a handle
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_granted_handle == '0))
    else $error("handle granted on a failed result");

  // the fresh counter only moves on an execute cycle
  a_fresh_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !exec_go |=> $stable(fresh_r))
    else $error("fresh counter changed outside execute");
`endif

endmodule
`default_nettype wire

### bench/hpa_checker.sv
// checker for the handle pool allocator: predicts each request's answer and compares results
`timescale 1ns / 1ps
module hpa_checker #(
  parameter int unsigned POOL_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_handle,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_granted_handle,
  input  logic [1:0] out_status,
  output int         mismatches,
  output int         pending
);
  import hpa_pkg::*;

  // handles are 8 bits wide, so larger pools are capped at the slot count
  localparam int unsigned POOL_LIMIT = (POOL_SIZE > SLOTS) ? SLOTS : POOL_SIZE;

  typedef struct packed {
    handle_t    granted;
    logic [1:0] status;
  } answer_t;

  handle_t            free_ring [SLOTS];
  handle_t            ring_rd;
  handle_t            ring_wr;
  logic [COUNT_W-1:0] ring_fill;
  logic               issued [SLOTS];
  logic [COUNT_W-1:0] fresh_next;
  answer_t            due_answers [$];

  function automatic answer_t serve_request(input logic [1:0] op, input handle_t h);
    answer_t a;
    a = '0;
    case (op)
      OP_ALLOC, OP_TRY: begin
        if (ring_fill != 0) begin
          a.granted = free_ring[ring_rd];
          ring_rd = ring_rd + 1'b1;
          ring_fill = ring_fill - 1'b1;
          issued[a.granted] = 1'b1;
        end else if (op == OP_TRY) begin
          a.status = ST_EMPTY;
        end else if (fresh_next < POOL_LIMIT) begin
          a.granted = fresh_next[HANDLE_W-1:0];
          issued[a.granted] = 1'b1;
          fresh_next = fresh_next + 1'b1;
        end else begin
          a.status = ST_EXHAUSTED;
        end
      end
      OP_RELEASE: begin
        if (!issued[h]) begin
          a.status = ST_NOT_OWNED;
        end else begin
          issued[h] = 1'b0;
          // queued handles are distinct, so the ring never overflows in practice
          if (ring_fill < SLOTS) begin
            free_ring[ring_wr] = h;
            ring_wr = ring_wr + 1'b1;
            ring_fill = ring_fill + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("hpa_checker: %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      foreach (issued[i]) issued[i] = 1'b0;
      ring_rd = '0;
      ring_wr = '0;
      ring_fill = '0;
      fresh_next = '0;
      due_answers.delete();
    end else begin
      if (in_valid && !in_stall)
        due_answers.push_back(serve_request(in_operation, in_handle));
      if (out_valid && !out_stall) begin
        if (due_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected result: handle %0d status %0d",
                                    out_granted_handle, out_status));
        end else begin
          want = due_answers.pop_front();
          if (out_granted_handle !== want.granted)
            report_mismatch($sformatf("granted handle %0d, expected %0d",
                                      out_granted_handle, want.granted));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        end
      end
    end
    pending = due_answers.size();
  end

endmodule

### bench/tb.sv
// testbench top for the handle pool allocator: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import hpa_pkg::*;

  localparam int unsigned POOL = 256;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {MIX_GRAB, MIX_RETURN, MIX_EVEN} mix_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [1:0] in_operation = OP_ALLOC;
  logic [7:0] in_handle = 8'd0;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire  [7:0] out_granted_handle;
  wire  [1:0] out_status;

  int         mismatches;
  int         pending;
  handle_t    held [$];
  logic [1:0] sent_ops [$];
  int         status_seen [4];
  int         requests_sent;
  bit         calm_in;
  bit         calm_out;
  int         stall_left;

  handle_pool_allocator #(.POOL_SIZE(POOL)) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_handle          (in_handle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted_handle (out_granted_handle),
    .out_status         (out_status)
  );

  hpa_checker #(.POOL_SIZE(POOL)) i_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_handle          (in_handle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted_handle (out_granted_handle),
    .out_status         (out_status),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: a fresh random stall after every accepted result, none while calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
        stall_left = calm_out ? 0 : $urandom_range(0, 4);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // track granted handles so releases can target them; outputs are stable at negedge
  always @(negedge clk) begin
    logic [1:0] op;
    if (rst_n && out_valid && !out_stall && sent_ops.size() != 0) begin
      op = sent_ops.pop_front();
      status_seen[out_status]++;
      if ((op == OP_ALLOC || op == OP_TRY) && out_status == ST_OK)
        held.push_back(out_granted_handle);
    end
  end

  task automatic send_request(input logic [1:0] op, input handle_t h);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_handle <= h;
    sent_ops.push_back(op);
    requests_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic random_request(input mix_t mix);
    int         r;
    int         idx;
    logic [1:0] op;
    handle_t    h;
    r = $urandom_range(0, 99);
    h = handle_t'($urandom_range(0, 255));
    case (mix)
      MIX_GRAB:   op = (r < 80) ? OP_ALLOC : (r < 88) ? OP_TRY :
                       (r < 96) ? OP_RELEASE : OP_UNUSED;
      MIX_RETURN: op = (r < 70) ? OP_RELEASE : (r < 82) ? OP_TRY :
                       (r < 95) ? OP_ALLOC : OP_UNUSED;
      default:    op = (r < 35) ? OP_ALLOC : (r < 55) ? OP_TRY :
                       (r < 92) ? OP_RELEASE : OP_UNUSED;
    endcase
    // most releases return a held handle, the rest are random and mostly refused
    if (op == OP_RELEASE && held.size() != 0 && $urandom_range(0, 9) != 0) begin
      idx = $urandom_range(0, held.size() - 1);
      h = held[idx];
      held.delete(idx);
    end
    send_request(op, h);
  endtask

  initial begin
    mix_t mix;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_TRY, 8'd0);        // free list empty
    send_request(OP_RELEASE, 8'd0);    // never issued
    send_request(OP_UNUSED, 8'hff);
    send_request(OP_ALLOC, 8'hff);
    send_request(OP_ALLOC, 8'h00);
    send_request(OP_RELEASE, 8'd0);
    send_request(OP_RELEASE, 8'd0);    // already freed
    send_request(OP_TRY, 8'hff);
    send_request(OP_ALLOC, 8'h5a);     // free list drained, fresh handle
    send_request(OP_RELEASE, 8'd255);
    send_request(OP_RELEASE, 8'd1);
    send_request(OP_RELEASE, 8'd2);
    send_request(OP_ALLOC, 8'h00);     // oldest freed comes back first
    send_request(OP_TRY, 8'ha5);
    send_request(OP_TRY, 8'h00);
    send_request(OP_UNUSED, 8'h00);
    send_request(OP_RELEASE, 8'd0);
    send_request(OP_RELEASE, 8'd1);
    send_request(OP_RELEASE, 8'd2);
    send_request(OP_RELEASE, 8'd200); // above the fresh counter
    drain();
    held.delete();

    // grab phases run the fresh counter into exhaustion, return phases refill the list
    for (int i = 0; i < 1000; i++) begin
      if (i % 50 == 0) calm_in = ($urandom_range(0, 3) == 0);
      if (i == 350 || i == 650 || i == 850) drain();
      if (i < 350 || i >= 850) mix = MIX_GRAB;
      else if (i < 650) mix = MIX_RETURN;
      else mix = MIX_EVEN;
      random_request(mix);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("tb: %0d requests sent with random gaps and result stalls", requests_sent);
    $display("tb: answers ok %0d, list empty %0d, refused release %0d, exhausted %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_OWNED],
             status_seen[ST_EXHAUSTED]);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
